// File: hdl/mrp_pkg.sv
// ----------------------------------------------------------------------------
// mrp_pkg
// Shared types and constants of the MIDI receive parser: byte codes, message
// kinds, register indexes, controller states and the control/status bundles.
// ----------------------------------------------------------------------------
package mrp_pkg;

   // default depth of the sysex frame buffer
   localparam int FRAME_CAPACITY_DEF = 64;

   // configuration port widths
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 7;

   // midi byte codes
   localparam logic [7:0] BYTE_SYSEX_START = 8'hF0;
   localparam logic [7:0] BYTE_SYSEX_END   = 8'hF7;
   localparam logic [7:0] BYTE_REALTIME    = 8'hF8;
   localparam logic [7:0] BYTE_NO_STATUS   = 8'h00;

   // channel message kinds (upper nibble of the status byte)
   localparam logic [3:0] KIND_CONTROL  = 4'hB;
   localparam logic [3:0] KIND_PROGRAM  = 4'hC;
   localparam logic [3:0] KIND_PRESSURE = 4'hD;

   // shortest frame that passes validation
   localparam int MIN_FRAME_LEN = 8;

   // result kinds
   localparam logic RESULT_PRESET = 1'b0;
   localparam logic RESULT_FRAME  = 1'b1;

   // configuration register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LISTEN_CHANNEL = 3'd0,
      CSR_BANK_SELECT    = 3'd1,
      CSR_MAKER_FIRST    = 3'd2,
      CSR_MAKER_SECOND   = 3'd3,
      CSR_MAKER_THIRD    = 3'd4,
      CSR_TAP_TEMPO      = 3'd5,
      CSR_TUNER          = 3'd6
   } csr_index_type;

   // controller states
   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } ctrl_state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic accept;   // input transaction taken this cycle
      logic issue;    // read the next frame byte from the buffer
      logic load;     // move the fetched frame byte into the output register
   } ctrl_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic out_full;   // output register holds a result
      logic frame_hit;  // accepted byte closes a valid frame
      logic rd_more;    // frame bytes left to read
      logic pend;       // a fetched frame byte waits in the read register
   } dp_status_type;

endpackage

// File: hdl/mrp_ram.sv
// ----------------------------------------------------------------------------
// mrp_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module mrp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/mrp_ctrl.sv
// ----------------------------------------------------------------------------
// mrp_ctrl
// Controller of the MIDI receive parser: takes input bytes while idle and
// sequences the read-out of a validated sysex frame.
// ----------------------------------------------------------------------------
module mrp_ctrl
   import mrp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   logic           out_free;

   // output register can take a new result this cycle
   assign out_free = !status.out_full || rsp_ready;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && out_free && status.frame_hit) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (!status.rd_more && !status.pend) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready  = 1'b0;
      cmd.accept = 1'b0;
      cmd.issue  = 1'b0;
      cmd.load   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = out_free;
            cmd.accept = req_valid && out_free;
         end
         ST_WALK: begin
            cmd.load  = status.pend && out_free;
            cmd.issue = status.rd_more && (!status.pend || cmd.load);
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// File: hdl/mrp_dp.sv
// ----------------------------------------------------------------------------
// mrp_dp
// Datapath of the MIDI receive parser: configuration registers, running
// status decode, sysex capture with on-the-fly checks, frame buffer and the
// output register.
// ----------------------------------------------------------------------------
module mrp_dp
   import mrp_pkg::*;
#(
   parameter int FRAME_CAPACITY = FRAME_CAPACITY_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ctrl_cmd_type           cmd,
   output dp_status_type          status,
   input  logic [7:0]             req_rx_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_result_kind,
   output logic [13:0]            rsp_preset_number,
   output logic [7:0]             rsp_frame_byte,
   output logic                   rsp_last_of_run,
   input  logic                   csr_valid,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int LW = $clog2(FRAME_CAPACITY + 1);
   localparam int AW = $clog2(FRAME_CAPACITY);

   // configuration registers
   logic [4:0] listen_ff;
   logic [6:0] bank_ctl_ff;
   logic [6:0] maker1_ff;
   logic [6:0] maker2_ff;
   logic [6:0] maker3_ff;
   logic [6:0] tap_ff;
   logic [6:0] tuner_ff;

   // parser state
   logic          in_sysex_ff, in_sysex_in;
   logic [LW-1:0] len_ff, len_in;
   logic [7:0]    rs_ff, rs_in;
   logic          dc_ff, dc_in;
   logic [6:0]    fd_ff, fd_in;
   logic [6:0]    bank_ff, bank_in;

   // frame trackers, written during capture
   logic [7:0] b1_ff, b1_in;
   logic [7:0] b2_ff, b2_in;
   logic [7:0] b3_ff, b3_in;
   logic [7:0] b5_ff, b5_in;
   logic [7:0] xor_ff, xor_in;
   logic [7:0] prev_ff, prev_in;

   // frame walk
   logic [LW-1:0] n_ff, n_in;
   logic [LW-1:0] idx_ff, idx_in;
   logic          pend_ff, pend_in;
   logic          pend_last_ff, pend_last_in;

   // output register
   logic        out_valid_ff, out_valid_in;
   logic        out_kind_ff, out_kind_in;
   logic [13:0] out_preset_ff, out_preset_in;
   logic [7:0]  out_byte_ff, out_byte_in;
   logic        out_last_ff, out_last_in;

   // byte decode
   logic          is_rt, is_start, is_end, is_status;
   logic          eff_sysex, overflow, wr_en;
   logic [LW-1:0] eff_len, frame_n;
   logic [7:0]    xor_body;
   logic          chk_skip, frame_ok, frame_hit;
   logic [3:0]    kind;
   logic          one_byte, chan_ok, data_path, complete;
   logic [6:0]    fd_eff;
   logic          preset_hit, bank_hit;
   logic [7:0]    rd_data;

   assign is_rt     = req_rx_byte >= BYTE_REALTIME;
   assign is_start  = req_rx_byte == BYTE_SYSEX_START;
   assign is_end    = req_rx_byte == BYTE_SYSEX_END;
   assign is_status = req_rx_byte[7];

   // sysex capture position
   assign eff_sysex = in_sysex_ff || is_start;
   assign eff_len   = is_start ? '0 : len_ff;
   assign overflow  = eff_len >= LW'(FRAME_CAPACITY);
   assign frame_n   = eff_len + LW'(1);
   assign wr_en     = cmd.accept && !is_rt && eff_sysex && !overflow;

   // frame checks at the end byte; xor_ff covers bytes up to the one before it
   assign xor_body = xor_ff ^ prev_ff;
   assign chk_skip = (b5_ff == {1'b0, tap_ff}) || (b5_ff == {1'b0, tuner_ff});
   assign frame_ok = (frame_n >= LW'(MIN_FRAME_LEN))
                   && (b1_ff == {1'b0, maker1_ff})
                   && (b2_ff == {1'b0, maker2_ff})
                   && (b3_ff == {1'b0, maker3_ff})
                   && (chk_skip || (prev_ff == {1'b0, xor_body[6:0]}));
   assign frame_hit = wr_en && is_end && frame_ok;

   // channel message decode
   assign kind      = rs_ff[7:4];
   assign one_byte  = (kind == KIND_PROGRAM) || (kind == KIND_PRESSURE);
   assign fd_eff    = dc_ff ? fd_ff : req_rx_byte[6:0];
   assign complete  = one_byte || dc_ff;
   assign chan_ok   = (listen_ff == 5'd0) || (listen_ff == ({1'b0, rs_ff[3:0]} + 5'd1));
   assign data_path = cmd.accept && !is_rt && !eff_sysex && !is_status
                    && (rs_ff != BYTE_NO_STATUS);
   assign preset_hit = data_path && complete && chan_ok && (kind == KIND_PROGRAM);
   assign bank_hit   = data_path && complete && chan_ok && (kind == KIND_CONTROL)
                     && (fd_eff == bank_ctl_ff);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         listen_ff   <= 5'd0;
         bank_ctl_ff <= 7'd0;
         maker1_ff   <= 7'd0;
         maker2_ff   <= 7'd1;
         maker3_ff   <= 7'd116;
         tap_ff      <= 7'd16;
         tuner_ff    <= 7'd13;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_LISTEN_CHANNEL: listen_ff   <= csr_data[4:0];
            CSR_BANK_SELECT:    bank_ctl_ff <= csr_data;
            CSR_MAKER_FIRST:    maker1_ff   <= csr_data;
            CSR_MAKER_SECOND:   maker2_ff   <= csr_data;
            CSR_MAKER_THIRD:    maker3_ff   <= csr_data;
            CSR_TAP_TEMPO:      tap_ff      <= csr_data;
            CSR_TUNER:          tuner_ff    <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // parser next state
   always_comb begin
      in_sysex_in = in_sysex_ff;
      len_in      = len_ff;
      rs_in       = rs_ff;
      dc_in       = dc_ff;
      fd_in       = fd_ff;
      bank_in     = bank_ff;
      b1_in       = b1_ff;
      b2_in       = b2_ff;
      b3_in       = b3_ff;
      b5_in       = b5_ff;
      xor_in      = xor_ff;
      prev_in     = prev_ff;
      if (cmd.accept && !is_rt) begin
         if (eff_sysex) begin
            if (is_start) begin
               rs_in = BYTE_NO_STATUS;
               dc_in = 1'b0;
            end
            if (overflow) begin
               in_sysex_in = 1'b0;
               len_in      = '0;
            end else begin
               in_sysex_in = 1'b1;
               len_in      = frame_n;
               xor_in      = (is_start ? 8'd0 : xor_ff) ^ req_rx_byte;
               prev_in     = req_rx_byte;
               if (eff_len == LW'(1)) b1_in = req_rx_byte;
               if (eff_len == LW'(2)) b2_in = req_rx_byte;
               if (eff_len == LW'(3)) b3_in = req_rx_byte;
               if (eff_len == LW'(5)) b5_in = req_rx_byte;
               // end of frame or stray status closes capture
               if (is_end || (is_status && !is_start)) begin
                  in_sysex_in = 1'b0;
                  len_in      = '0;
               end
            end
         end else if (is_status) begin
            rs_in = (req_rx_byte < BYTE_SYSEX_START) ? req_rx_byte : BYTE_NO_STATUS;
            dc_in = 1'b0;
         end else if (rs_ff != BYTE_NO_STATUS) begin
            if (!complete) begin
               fd_in = req_rx_byte[6:0];
               dc_in = 1'b1;
            end else begin
               dc_in = 1'b0;
               if (bank_hit) begin
                  bank_in = req_rx_byte[6:0];
               end
            end
         end
      end
   end

   // frame walk next state
   always_comb begin
      n_in         = n_ff;
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      pend_last_in = pend_last_ff;
      if (frame_hit) begin
         n_in   = frame_n;
         idx_in = '0;
      end
      if (cmd.issue) begin
         idx_in       = idx_ff + LW'(1);
         pend_in      = 1'b1;
         pend_last_in = (idx_ff + LW'(1)) == n_ff;
      end else if (cmd.load) begin
         pend_in = 1'b0;
      end
   end

   // output register next state
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_kind_in   = out_kind_ff;
      out_preset_in = out_preset_ff;
      out_byte_in   = out_byte_ff;
      out_last_in   = out_last_ff;
      if (preset_hit) begin
         out_valid_in  = 1'b1;
         out_kind_in   = RESULT_PRESET;
         out_preset_in = {bank_ff, fd_eff};
         out_byte_in   = 8'd0;
         out_last_in   = 1'b1;
      end else if (cmd.load) begin
         out_valid_in  = 1'b1;
         out_kind_in   = RESULT_FRAME;
         out_preset_in = 14'd0;
         out_byte_in   = rd_data;
         out_last_in   = pend_last_ff;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_sysex_ff  <= 1'b0;
         len_ff       <= '0;
         rs_ff        <= BYTE_NO_STATUS;
         dc_ff        <= 1'b0;
         fd_ff        <= 7'd0;
         bank_ff      <= 7'd0;
         n_ff         <= '0;
         idx_ff       <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_sysex_ff  <= in_sysex_in;
         len_ff       <= len_in;
         rs_ff        <= rs_in;
         dc_ff        <= dc_in;
         fd_ff        <= fd_in;
         bank_ff      <= bank_in;
         n_ff         <= n_in;
         idx_ff       <= idx_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      b1_ff         <= b1_in;
      b2_ff         <= b2_in;
      b3_ff         <= b3_in;
      b5_ff         <= b5_in;
      xor_ff        <= xor_in;
      prev_ff       <= prev_in;
      pend_last_ff  <= pend_last_in;
      out_kind_ff   <= out_kind_in;
      out_preset_ff <= out_preset_in;
      out_byte_ff   <= out_byte_in;
      out_last_ff   <= out_last_in;
   end

   // frame buffer
   mrp_ram #(
      .WIDTH (8),
      .DEPTH (FRAME_CAPACITY)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (eff_len[AW-1:0]),
      .wr_data (req_rx_byte),
      .rd_en   (cmd.issue),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   // status to controller
   assign status.out_full  = out_valid_ff;
   assign status.frame_hit = frame_hit;
   assign status.rd_more   = idx_ff < n_ff;
   assign status.pend      = pend_ff;

   assign rsp_valid         = out_valid_ff;
   assign rsp_result_kind   = out_kind_ff;
   assign rsp_preset_number = out_preset_ff;
   assign rsp_frame_byte    = out_byte_ff;
   assign rsp_last_of_run   = out_last_ff;

endmodule

// File: hdl/midi_receive_parser.sv
// ----------------------------------------------------------------------------
// midi_receive_parser
// MIDI receive parser: decodes program and bank-select messages into preset
// numbers and captures, validates and replays sysex frames.
//
//   channel  direction  payload
//   req_     in         rx_byte
//   rsp_     out        result_kind, preset_number, frame_byte, last_of_run
//   csr_     in         index, data (register write, always ready)
//
// A preset result sits in the output register the cycle after the byte that
// completes it is taken. A byte that closes a valid frame starts a read-out
// of the frame buffer at one byte a cycle while the output is not stalled.
// No input is taken during the read-out. A stalled output holds its result
// and the next byte is taken as soon as that result leaves.
// Reset clears all control state; the frame buffer needs no clearing.
// ----------------------------------------------------------------------------
module midi_receive_parser
   import mrp_pkg::*;
#(
   parameter int FRAME_CAPACITY = FRAME_CAPACITY_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_rx_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_result_kind,
   output logic [13:0]            rsp_preset_number,
   output logic [7:0]             rsp_frame_byte,
   output logic                   rsp_last_of_run,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // register writes never stall
   assign csr_ready = 1'b1;

   // controller
   mrp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   mrp_dp #(
      .FRAME_CAPACITY (FRAME_CAPACITY)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_preset_number (rsp_preset_number),
      .rsp_frame_byte    (rsp_frame_byte),
      .rsp_last_of_run   (rsp_last_of_run),
      .csr_valid         (csr_valid),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the MIDI receive parser. A byte-level tracker keeps
// its own copy of the parser state and the register settings, turns every
// accepted byte into the preset or sysex results it should cause, and checks
// each result transaction against the oldest one still due. A directed
// sequence comes first, then phases of random well-formed messages and frames
// mixed with broken frames and noise, each phase under new register settings
// and one of four patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import mrp_pkg::*;

   localparam int FRAME_CAP       = FRAME_CAPACITY_DEF;
   localparam int ITEMS_PER_PHASE = 20;
   localparam int RANDOM_PHASES   = 8;
   localparam int DRAIN_CYCLES    = FRAME_CAP + 8;
   localparam int WATCHDOG_LIMIT  = 4000;

   localparam logic [7:0] BYTE_TOP_REALTIME = 8'hFF;
   localparam logic [7:0] SYS_COMMON_FIRST  = 8'hF1;
   localparam logic [3:0] KIND_NOTE_ON      = 4'h9;
   localparam logic [2:0] CSR_UNUSED_INDEX  = 3'd7;

   typedef struct packed {
      logic        kind;
      logic [13:0] preset;
      logic [7:0]  fbyte;
      logic        last;
   } parser_result_type;

   typedef enum int {
      FRAME_GOOD,
      FRAME_EXEMPT,
      FRAME_BAD_SUM,
      FRAME_BAD_MAKER,
      FRAME_SHORT,
      FRAME_RESTART,
      FRAME_STRAY,
      FRAME_OVERFLOW
   } frame_shape_type;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   // --------------------------------------------------------------------------
   // parser tracker: register copy, parser state and the results still due
   // --------------------------------------------------------------------------
   class midi_parse_tracker;
      logic [4:0] listen_channel;
      logic [6:0] bank_ctrl;
      logic [6:0] maker_first;
      logic [6:0] maker_second;
      logic [6:0] maker_third;
      logic [6:0] tap_fn;
      logic [6:0] tuner_fn;

      bit         in_frame;
      int         frame_len;
      logic [7:0] frame_buf [FRAME_CAP];
      logic [7:0] run_status;
      bit         data_cnt;
      logic [6:0] first_byte;
      logic [6:0] bank;

      parser_result_type due_results [$];
      int mismatches;

      function new();
         listen_channel = 5'd0;
         bank_ctrl      = 7'd0;
         maker_first    = 7'd0;
         maker_second   = 7'd1;
         maker_third    = 7'd116;
         tap_fn         = 7'd16;
         tuner_fn       = 7'd13;
         in_frame       = 1'b0;
         frame_len      = 0;
         run_status     = BYTE_NO_STATUS;
         data_cnt       = 1'b0;
         first_byte     = 7'd0;
         bank           = 7'd0;
         mismatches     = 0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [6:0] v);
         case (idx)
            CSR_LISTEN_CHANNEL: listen_channel = v[4:0];
            CSR_BANK_SELECT:    bank_ctrl      = v;
            CSR_MAKER_FIRST:    maker_first    = v;
            CSR_MAKER_SECOND:   maker_second   = v;
            CSR_MAKER_THIRD:    maker_third    = v;
            CSR_TAP_TEMPO:      tap_fn         = v;
            CSR_TUNER:          tuner_fn       = v;
            default: ;
         endcase
      endfunction

      function int pending();
         return due_results.size();
      endfunction

      // length, maker bytes, end byte and masked xor unless the function is exempt
      function bit frame_ok();
         logic [7:0] sum;
         bit ok;
         if (frame_len < MIN_FRAME_LEN || frame_len > FRAME_CAP) return 1'b0;
         ok = frame_buf[0] == BYTE_SYSEX_START &&
              frame_buf[1] == {1'b0, maker_first} &&
              frame_buf[2] == {1'b0, maker_second} &&
              frame_buf[3] == {1'b0, maker_third} &&
              frame_buf[frame_len-1] == BYTE_SYSEX_END;
         if (frame_buf[5] != {1'b0, tap_fn} && frame_buf[5] != {1'b0, tuner_fn}) begin
            sum = 8'h00;
            for (int i = 0; i < frame_len - 2; i++) sum ^= frame_buf[i];
            ok = ok && frame_buf[frame_len-2] == {1'b0, sum[6:0]};
         end
         return ok;
      endfunction

      // one accepted input transaction
      function void note_rx_byte(logic [7:0] b);
         logic [3:0] kind;
         bit two_data;
         if (b >= BYTE_REALTIME) return;

         if (b == BYTE_SYSEX_START) begin
            in_frame   = 1'b1;
            frame_len  = 0;
            run_status = BYTE_NO_STATUS;
            data_cnt   = 1'b0;
         end

         // sysex capture
         if (in_frame) begin
            if (frame_len >= FRAME_CAP) begin
               in_frame  = 1'b0;
               frame_len = 0;
               return;
            end
            frame_buf[frame_len] = b;
            frame_len++;
            if (b == BYTE_SYSEX_END) begin
               in_frame = 1'b0;
               if (frame_ok()) begin
                  for (int i = 0; i < frame_len; i++)
                     due_results.push_back('{RESULT_FRAME, 14'd0, frame_buf[i],
                                             (i == frame_len - 1)});
               end
               frame_len = 0;
               return;
            end
            if (b != BYTE_SYSEX_START && b[7]) begin
               in_frame  = 1'b0;
               frame_len = 0;
            end
            return;
         end

         // status bytes outside a frame
         if (b[7]) begin
            run_status = (b < BYTE_SYSEX_START) ? b : BYTE_NO_STATUS;
            data_cnt   = 1'b0;
            return;
         end
         if (run_status == BYTE_NO_STATUS) return;

         // data bytes under running status
         kind     = run_status[7:4];
         two_data = !(kind == KIND_PROGRAM || kind == KIND_PRESSURE);
         if (!data_cnt) begin
            first_byte = b[6:0];
            if (two_data) begin
               data_cnt = 1'b1;
               return;
            end
         end
         data_cnt = 1'b0;

         if (!(listen_channel == 5'd0 ||
               listen_channel == 5'(run_status[3:0]) + 5'd1)) return;
         if (kind == KIND_CONTROL && first_byte == bank_ctrl) begin
            bank = b[6:0];
            return;
         end
         if (kind == KIND_PROGRAM)
            due_results.push_back('{RESULT_PRESET, {bank, first_byte}, 8'h00, 1'b1});
      endfunction

      task report_mismatch(string what);
         mismatches++;
         $display("%0t ns: mismatch, %s", $time, what);
      endtask

      // one accepted result transaction against the oldest one due
      task check_result(logic kind, logic [13:0] preset, logic [7:0] fbyte, logic last);
         parser_result_type want;
         if (due_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result kind=%0b preset=%0d byte=%02h last=%0b",
                                      kind, preset, fbyte, last));
            return;
         end
         want = due_results.pop_front();
         if (kind !== want.kind)
            report_mismatch($sformatf("result_kind got %0b want %0b", kind, want.kind));
         if (preset !== want.preset)
            report_mismatch($sformatf("preset_number got %0d want %0d", preset, want.preset));
         if (fbyte !== want.fbyte)
            report_mismatch($sformatf("frame_byte got %02h want %02h", fbyte, want.fbyte));
         if (last !== want.last)
            report_mismatch($sformatf("last_of_run got %0b want %0b", last, want.last));
      endtask
   endclass

   // --------------------------------------------------------------------------
   // block under test
   // --------------------------------------------------------------------------
   logic                   clock;
   logic                   reset             = 1'b1;
   logic                   req_valid         = 1'b0;
   logic                   req_ready;
   logic [7:0]             req_rx_byte       = 8'h00;
   logic                   rsp_valid;
   logic                   rsp_ready         = 1'b0;
   logic                   rsp_result_kind;
   logic [13:0]            rsp_preset_number;
   logic [7:0]             rsp_frame_byte;
   logic                   rsp_last_of_run;
   logic                   csr_valid         = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index         = '0;
   logic [CSR_DATA_W-1:0]  csr_data          = '0;

   midi_receive_parser dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_preset_number (rsp_preset_number),
      .rsp_frame_byte    (rsp_frame_byte),
      .rsp_last_of_run   (rsp_last_of_run),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   midi_parse_tracker tracker = new();

   logic [7:0] stim [$];
   int         stim_items;
   bit         sprinkle_realtime;
   int         send_idle_pct;
   int         recv_stall_pct;
   int         quiet_cycles;
   logic [6:0] cfg_vals [8];

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver stalls
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.check_result(rsp_result_kind, rsp_preset_number, rsp_frame_byte,
                              rsp_last_of_run);
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // --------------------------------------------------------------------------
   // byte stream builders
   // --------------------------------------------------------------------------
   function automatic void add_byte(logic [7:0] b);
      if (sprinkle_realtime && $urandom_range(15) == 0)
         stim.push_back(BYTE_REALTIME | 8'($urandom_range(7)));
      stim.push_back(b);
      if (b < BYTE_REALTIME) stim_items++;
   endfunction

   // mostly the listened channel when there is one
   function automatic logic [3:0] pick_channel();
      if (tracker.listen_channel >= 5'd1 && tracker.listen_channel <= 5'd16 &&
          $urandom_range(1) == 0)
         return 4'(tracker.listen_channel - 5'd1);
      return 4'($urandom_range(15));
   endfunction

   function automatic void add_program();
      add_byte({KIND_PROGRAM, pick_channel()});
      add_byte({1'b0, 7'($urandom_range(127))});
      // running status repeat
      if ($urandom_range(2) == 0) add_byte({1'b0, 7'($urandom_range(127))});
   endfunction

   function automatic void add_bank();
      add_byte({KIND_CONTROL, pick_channel()});
      if ($urandom_range(3) != 0) add_byte({1'b0, tracker.bank_ctrl});
      else add_byte({1'b0, 7'($urandom_range(127))});
      add_byte({1'b0, 7'($urandom_range(127))});
   endfunction

   function automatic void add_channel_traffic();
      int reps;
      reps = $urandom_range(1, 3);
      add_byte({4'($urandom_range(8, 14)), 4'($urandom_range(15))});
      for (int i = 0; i < reps; i++) add_byte({1'b0, 7'($urandom_range(127))});
   endfunction

   function automatic void add_frame(frame_shape_type shape);
      logic [7:0] fr [$];
      logic [7:0] sum;
      logic [7:0] stray;
      logic [6:0] fn;
      int n;
      int pre;
      if (shape == FRAME_OVERFLOW) n = FRAME_CAP + $urandom_range(1, 4);
      else if (shape == FRAME_SHORT) n = $urandom_range(2, MIN_FRAME_LEN - 1);
      else if ($urandom_range(11) == 0) n = FRAME_CAP;
      else n = $urandom_range(MIN_FRAME_LEN, 12);

      if (shape == FRAME_EXEMPT)
         fn = $urandom_range(1) ? tracker.tap_fn : tracker.tuner_fn;
      else
         do fn = 7'($urandom_range(127));
         while (fn == tracker.tap_fn || fn == tracker.tuner_fn);

      // header, function byte and random body
      for (int i = 0; i < n; i++) begin
         if (i == 0)          fr.push_back(BYTE_SYSEX_START);
         else if (i == n - 1) fr.push_back(BYTE_SYSEX_END);
         else if (i == 1)     fr.push_back({1'b0, tracker.maker_first});
         else if (i == 2)     fr.push_back({1'b0, tracker.maker_second});
         else if (i == 3)     fr.push_back({1'b0, tracker.maker_third});
         else if (i == 5)     fr.push_back({1'b0, fn});
         else                 fr.push_back({1'b0, 7'($urandom_range(127))});
      end
      sum = 8'h00;
      for (int i = 0; i < n - 2; i++) sum ^= fr[i];
      if (n >= 3) fr[n-2] = {1'b0, sum[6:0]};

      // damage
      case (shape)
         FRAME_BAD_SUM:   fr[n-2] ^= 8'h01 << $urandom_range(6);
         FRAME_BAD_MAKER: fr[$urandom_range(1, 3)] ^= 8'h01 << $urandom_range(6);
         FRAME_STRAY: begin
            stray = 8'($urandom_range(8'h80, 8'hF6));
            if (stray == BYTE_SYSEX_START) stray = BYTE_SYSEX_START + 8'd1;
            fr[$urandom_range(1, n - 2)] = stray;
         end
         FRAME_RESTART: begin
            pre = $urandom_range(0, 4);
            add_byte(BYTE_SYSEX_START);
            for (int i = 0; i < pre; i++) add_byte({1'b0, 7'($urandom_range(127))});
         end
         default: ;
      endcase
      foreach (fr[i]) add_byte(fr[i]);
   endfunction

   function automatic void build_directed();
      sprinkle_realtime = 1'b0;
      add_byte(BYTE_REALTIME);
      add_byte({KIND_PROGRAM, 4'h3});
      add_byte(8'h05);
      // bank select then the largest preset
      add_byte({KIND_CONTROL, 4'h0});
      add_byte({1'b0, tracker.bank_ctrl});
      add_byte(8'h7F);
      add_byte({KIND_PROGRAM, 4'h0});
      add_byte(8'h7F);
      add_byte(8'h00);
      // one-byte pressure, then system common clears running status
      add_byte({KIND_PRESSURE, 4'hF});
      add_byte(8'h40);
      add_byte(SYS_COMMON_FIRST);
      add_byte(8'h12);
      // restart inside a frame, realtime inside a frame, checksum skipped
      add_byte(BYTE_SYSEX_START);
      add_byte(8'h33);
      add_byte(BYTE_SYSEX_START);
      add_byte({1'b0, tracker.maker_first});
      add_byte(BYTE_TOP_REALTIME);
      add_byte({1'b0, tracker.maker_second});
      add_byte({1'b0, tracker.maker_third});
      add_byte(8'h22);
      add_byte({1'b0, tracker.tap_fn});
      add_byte(8'h55);
      add_byte(BYTE_SYSEX_END);
      // stray status aborts the frame, following data has no status
      add_byte(BYTE_SYSEX_START);
      add_byte(8'h00);
      add_byte({KIND_NOTE_ON, 4'h0});
      add_byte(8'h40);
   endfunction

   function automatic void build_random(int target);
      int r;
      sprinkle_realtime = 1'b1;
      stim_items = 0;
      while (stim_items < target) begin
         r = $urandom_range(99);
         if (r < 28)      add_program();
         else if (r < 42) add_bank();
         else if (r < 57) add_frame(FRAME_GOOD);
         else if (r < 66) add_frame(FRAME_EXEMPT);
         else if (r < 74) add_channel_traffic();
         else if (r < 90) add_frame(frame_shape_type'($urandom_range(FRAME_BAD_SUM,
                                                                     FRAME_OVERFLOW)));
         else add_byte(8'($urandom_range(255)));
      end
   endfunction

   // --------------------------------------------------------------------------
   // drivers
   // --------------------------------------------------------------------------
   task automatic send_byte(logic [7:0] b, bit is_last);
      int idle;
      idle = 0;
      while ($urandom_range(99) < send_idle_pct) idle++;
      if (idle > 0) begin
         req_valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      tracker.note_rx_byte(b);
      if (is_last) req_valid <= 1'b0;
   endtask

   task automatic drive_stream();
      foreach (stim[i]) send_byte(stim[i], i == stim.size() - 1);
      stim.delete();
   endtask

   // all results in, then room for a read-out that yields nothing
   task automatic wait_drain();
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic program_registers();
      for (int i = 0; i < 8; i++) begin
         csr_valid <= 1'b1;
         csr_index <= 3'(i);
         csr_data  <= cfg_vals[i];
         do @(posedge clock); while (!csr_ready);
         tracker.write_reg(3'(i), cfg_vals[i]);
      end
      csr_valid <= 1'b0;
   endtask

   // register settings per phase, extremes first
   task automatic choose_settings(int phase);
      foreach (cfg_vals[i]) cfg_vals[i] = 7'($urandom_range(127));
      cfg_vals[CSR_LISTEN_CHANNEL] = 7'($urandom_range(16));
      case (phase)
         1: begin
            cfg_vals[CSR_LISTEN_CHANNEL] = 7'd0;
            cfg_vals[CSR_BANK_SELECT]    = 7'd127;
            cfg_vals[CSR_MAKER_FIRST]    = 7'd0;
            cfg_vals[CSR_MAKER_SECOND]   = 7'd0;
            cfg_vals[CSR_MAKER_THIRD]    = 7'd0;
            cfg_vals[CSR_TAP_TEMPO]      = 7'd0;
            cfg_vals[CSR_TUNER]          = 7'd127;
         end
         2: begin
            cfg_vals[CSR_LISTEN_CHANNEL] = 7'd1;
            cfg_vals[CSR_BANK_SELECT]    = 7'd0;
            cfg_vals[CSR_MAKER_FIRST]    = 7'd127;
            cfg_vals[CSR_MAKER_SECOND]   = 7'd127;
            cfg_vals[CSR_MAKER_THIRD]    = 7'd127;
            cfg_vals[CSR_TAP_TEMPO]      = 7'd127;
            cfg_vals[CSR_TUNER]          = 7'd0;
         end
         3: cfg_vals[CSR_LISTEN_CHANNEL] = 7'd16;
         // above sixteen: no channel matches
         4: cfg_vals[CSR_LISTEN_CHANNEL] = 7'd127;
         5: cfg_vals[CSR_LISTEN_CHANNEL] = 7'd17;
         7: cfg_vals[CSR_LISTEN_CHANNEL] = 7'd0;
         default: ;
      endcase
   endtask

   task automatic set_idling(idle_mode_type mode);
      case (mode)
         IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         IDLE_SENDER:   begin send_idle_pct = 84; recv_stall_pct = 0;  end
         IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 84; end
         default:       begin send_idle_pct = 9;  recv_stall_pct = 9;  end
      endcase
   endtask

   // --------------------------------------------------------------------------
   // run
   // --------------------------------------------------------------------------
   initial begin
      set_idling(IDLE_NONE);
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part under reset settings
      build_directed();
      drive_stream();
      wait_drain();

      // random phases
      for (int p = 1; p <= RANDOM_PHASES; p++) begin
         choose_settings(p);
         program_registers();
         set_idling(idle_mode_type'(p % 4));
         build_random(ITEMS_PER_PHASE);
         drive_stream();
         wait_drain();
      end

      if (tracker.mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
